// ===== design/amgs_pkg.sv =====
// Shared types and constants of the adjacency matrix graph store.
// No dependencies; imported by every module of the block.
package amgs_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int VERTEX_W         = 6;
   localparam int COUNT_W          = 7;
   localparam int ROW_W            = 64;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   // register index of start_count in the CSR map
   localparam logic REG_START_COUNT = 1'b0;

   typedef enum logic [1:0] {
      CMD_ADD_EDGE      = 2'd0,
      CMD_ADD_VERTEX    = 2'd1,
      CMD_REMOVE_VERTEX = 2'd2,
      CMD_READ_ROW      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_SAME      = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // control of the row memory
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_row;
      logic clr_all;
   } mem_ctl_type;

endpackage

// ===== design/amgs_row_mem.sv =====
// Row memory of the adjacency matrix: one synchronous RAM row per vertex,
// registered read, with a valid bit per row. Uses amgs_pkg.
module amgs_row_mem import amgs_pkg::*; #(
   parameter int DEPTH = MAX_VERTICES_DEF,
   parameter int WIDTH = MAX_VERTICES_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  mem_ctl_type      ctl,
   input  logic [AW-1:0]    rd_addr,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    clr_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] row_ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         row_ram_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= row_ram_ff[rd_addr];
      end
   end

   // a row that is not valid reads as zero
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clr_all) begin
         valid_in = '0;
      end else begin
         if (ctl.wr_en) begin
            valid_in[wr_addr] = 1'b1;
         end
         if (ctl.clr_row) begin
            valid_in[clr_addr] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== design/amgs_ctrl.sv =====
// Command sequencer: decodes a request, runs the read-modify-write passes
// over the row memory and holds the result register. Uses amgs_pkg.
module amgs_ctrl import amgs_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int AW           = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cfg_wr,
   input  logic [COUNT_W-1:0]      cfg_count,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [1:0]              req_cmd,
   input  logic [VERTEX_W-1:0]     req_vertex_a,
   input  logic [VERTEX_W-1:0]     req_vertex_b,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [1:0]              rsp_status,
   output logic [ROW_W-1:0]        rsp_row_bits,
   output logic [COUNT_W-1:0]      rsp_vertex_count,
   output mem_ctl_type             mem_ctl,
   output logic [AW-1:0]           mem_rd_addr,
   output logic [AW-1:0]           mem_wr_addr,
   output logic [MAX_VERTICES-1:0] mem_wr_data,
   output logic [AW-1:0]           mem_clr_addr,
   input  logic [MAX_VERTICES-1:0] mem_rd_data
);

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_VERTICES);
   localparam logic [AW-1:0]      ONE_IDX   = AW'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EDGE_A,
      S_EDGE_B,
      S_READ,
      S_REMOVE,
      S_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [VERTEX_W-1:0]  va_ff, va_in;
   logic [VERTEX_W-1:0]  vb_ff, vb_in;
   logic [AW-1:0]        row_ff, row_in;
   status_type           status_ff, status_in;
   logic [ROW_W-1:0]     result_ff, result_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [ROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [COUNT_W-1:0]   cnt_m1;
   logic [COUNT_W-1:0]   cnt_m2;
   logic [AW-1:0]        next_row;
   logic                 va_miss;
   logic                 vb_miss;

   // remove column va: bits above va move down by one
   function automatic logic [MAX_VERTICES-1:0] drop_col(
      input logic [MAX_VERTICES-1:0] w,
      input logic [AW-1:0]           col
   );
      logic [MAX_VERTICES-1:0] r;
      r = '0;
      for (int j = 0; j < MAX_VERTICES; j++) begin
         if (j < int'(col)) begin
            r[j] = w[j];
         end else if (j + 1 < MAX_VERTICES) begin
            r[j] = w[j+1];
         end
      end
      return r;
   endfunction

   // source row for destination r while closing the gap at va
   function automatic logic [AW-1:0] src_row(
      input logic [AW-1:0] r,
      input logic [AW-1:0] col
   );
      return (r >= col) ? r + ONE_IDX : r;
   endfunction

   assign cnt_m1   = cnt_ff - COUNT_W'(1);
   assign cnt_m2   = cnt_ff - COUNT_W'(2);
   assign next_row = row_ff + ONE_IDX;
   assign va_miss  = COUNT_W'(req_vertex_a) >= cnt_ff;
   assign vb_miss  = COUNT_W'(req_vertex_b) >= cnt_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      row_in        = row_ff;
      status_in     = status_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_count_in  = rsp_count_ff;
      mem_ctl       = '0;
      mem_rd_addr   = '0;
      mem_wr_addr   = row_ff;
      mem_wr_data   = '0;
      mem_clr_addr  = '0;
      req_tready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               va_in     = req_vertex_a;
               vb_in     = req_vertex_b;
               status_in = ST_OK;
               result_in = '0;
               state_in  = S_RESP;
               unique case (cmd_type'(req_cmd))
                  CMD_ADD_EDGE: begin
                     if (va_miss || vb_miss) begin
                        status_in = ST_NOT_FOUND;
                     end else if (req_vertex_a == req_vertex_b) begin
                        status_in = ST_SAME;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = req_vertex_a[AW-1:0];
                        state_in      = S_EDGE_A;
                     end
                  end
                  CMD_ADD_VERTEX: begin
                     if (cnt_ff >= MAX_COUNT) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_ctl.clr_row = 1'b1;
                        mem_clr_addr    = cnt_ff[AW-1:0];
                        cnt_in          = cnt_ff + COUNT_W'(1);
                     end
                  end
                  CMD_REMOVE_VERTEX: begin
                     if (va_miss) begin
                        status_in = ST_NOT_FOUND;
                     end else if (cnt_ff == COUNT_W'(1)) begin
                        // only vertex left: drop row zero at once
                        mem_ctl.clr_row = 1'b1;
                        mem_clr_addr    = '0;
                        cnt_in          = '0;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = src_row('0, req_vertex_a[AW-1:0]);
                        row_in        = '0;
                        state_in      = S_REMOVE;
                     end
                  end
                  CMD_READ_ROW: begin
                     if (va_miss) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = req_vertex_a[AW-1:0];
                        state_in      = S_READ;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_EDGE_A: begin
            // write row a back, fetch row b in the same cycle
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = va_ff[AW-1:0];
            mem_wr_data   = mem_rd_data | (MAX_VERTICES'(1) << vb_ff[AW-1:0]);
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = vb_ff[AW-1:0];
            state_in      = S_EDGE_B;
         end
         S_EDGE_B: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = vb_ff[AW-1:0];
            mem_wr_data   = mem_rd_data | (MAX_VERTICES'(1) << va_ff[AW-1:0]);
            state_in      = S_RESP;
         end
         S_READ: begin
            result_in = ROW_W'(mem_rd_data);
            state_in  = S_RESP;
         end
         S_REMOVE: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = row_ff;
            mem_wr_data   = drop_col(mem_rd_data, va_ff[AW-1:0]);
            if (row_ff == cnt_m2[AW-1:0]) begin
               // last live row goes empty
               mem_ctl.clr_row = 1'b1;
               mem_clr_addr    = cnt_m1[AW-1:0];
               cnt_in          = cnt_m1;
               state_in        = S_RESP;
            end else begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = src_row(next_row, va_ff[AW-1:0]);
               row_in        = next_row;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_row_in    = result_ff;
               rsp_count_in  = cnt_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg_wr) begin
         mem_ctl.clr_all = 1'b1;
         cnt_in          = cfg_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      va_ff         <= va_in;
      vb_ff         <= vb_in;
      row_ff        <= row_in;
      status_ff     <= status_in;
      result_ff     <= result_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_row_bits     = rsp_row_ff;
   assign rsp_vertex_count = rsp_count_ff;

endmodule

// ===== design/adjacency_matrix_graph_store.sv =====
// Undirected graph store on an adjacency bit matrix: top level with the
// stream ports and CSR. Uses amgs_pkg, amgs_ctrl and amgs_row_mem.
//
// The block keeps up to MAX_VERTICES vertices as one memory row per vertex
// and answers every request with one response: status, the row bits (read
// row only) and the vertex count afterwards. One request is worked on at a
// time, through a single-port-write, registered-read row memory. Add edge
// is a read-modify-write of both end rows; in remove vertex every live row
// loses the removed column and later rows move down. A response waits in
// the output register without blocking the next accept. Writing
// start_count clears the matrix at once through per-row valid bits; no
// clearing pass runs.
module adjacency_matrix_graph_store import amgs_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,  // [5:0] vertex_a, [11:6] vertex_b, rest zero
   input  logic [1:0]            req_tuser,  // [1:0] cmd
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,  // [63:0] row_bits, [70:64] vertex_count
   output logic [1:0]            rsp_tuser,  // [1:0] status
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_VERTICES);

   logic [COUNT_W-1:0]      start_count_ff, start_count_in;
   logic                    cfg_wr;
   logic [COUNT_W-1:0]      cfg_count;
   logic [ROW_W-1:0]        rsp_row_bits;
   logic [COUNT_W-1:0]      rsp_vertex_count;
   mem_ctl_type             mem_ctl;
   logic [AW-1:0]           mem_rd_addr;
   logic [AW-1:0]           mem_wr_addr;
   logic [AW-1:0]           mem_clr_addr;
   logic [MAX_VERTICES-1:0] mem_wr_data;
   logic [MAX_VERTICES-1:0] mem_rd_data;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_START_COUNT);
   assign start_count_in = cfg_wr ? csr_pwdata[COUNT_W-1:0] : start_count_ff;
   // saturate the live count at capacity
   assign cfg_count  = (csr_pwdata[COUNT_W-1:0] > MAX_COUNT) ?
                       MAX_COUNT : csr_pwdata[COUNT_W-1:0];
   assign csr_prdata = (csr_paddr[2] == REG_START_COUNT) ?
                       CSR_DATA_W'(start_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_count_ff <= '0;
      end else begin
         start_count_ff <= start_count_in;
      end
   end

   amgs_ctrl #(
      .MAX_VERTICES (MAX_VERTICES),
      .AW           (AW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg_wr           (cfg_wr),
      .cfg_count        (cfg_count),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_cmd          (req_tuser),
      .req_vertex_a     (req_tdata[5:0]),
      .req_vertex_b     (req_tdata[11:6]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_status       (rsp_tuser),
      .rsp_row_bits     (rsp_row_bits),
      .rsp_vertex_count (rsp_vertex_count),
      .mem_ctl          (mem_ctl),
      .mem_rd_addr      (mem_rd_addr),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_clr_addr     (mem_clr_addr),
      .mem_rd_data      (mem_rd_data)
   );

   amgs_row_mem #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (MAX_VERTICES),
      .AW    (AW)
   ) u_row_mem (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mem_ctl),
      .rd_addr  (mem_rd_addr),
      .wr_addr  (mem_wr_addr),
      .wr_data  (mem_wr_data),
      .clr_addr (mem_clr_addr),
      .rd_data  (mem_rd_data)
   );

   assign rsp_tdata = {1'b0, rsp_vertex_count, rsp_row_bits};

endmodule
